// ----- hdl/aer_pkg.sv -----
// ----------------------------------------------------------------------------
// aer_pkg
// shared types and constants for the aging event record table
// ----------------------------------------------------------------------------
package aer_pkg;

    localparam int ENTRIES_DEF    = 32;
    localparam int OWNER_BITS_DEF = 16;

    localparam int ACT_W      = 2;
    localparam int OWNER_IN_W = 16;
    localparam int DELTA_W    = 16;
    localparam int AGE_W      = 24;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 32;

    localparam logic [AGE_W-1:0] AGE_LIMIT = 24'd10238976;

    localparam logic [ACT_W-1:0] ACT_RECORD = 2'd0;
    localparam logic [ACT_W-1:0] ACT_TICK   = 2'd1;
    localparam logic [ACT_W-1:0] ACT_QUERY  = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    // control from the sequencer to the scan datapath
    typedef struct packed {
        logic clear;
        logic data_vld;
    } scan_ctl_t;

endpackage

// ----- hdl/aer_ram.sv -----
// ----------------------------------------------------------------------------
// aer_ram
// simple dual port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module aer_ram
    import aer_pkg::*;
#(
    parameter int DEPTH = ENTRIES_DEF,
    parameter int WIDTH = AGE_W + OWNER_IN_W
)
(
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- hdl/aer_scan.sv -----
// ----------------------------------------------------------------------------
// aer_scan
// running oldest-entry search and per-owner youngest-age search over the
// entries streamed out of the ram
// ----------------------------------------------------------------------------
module aer_scan
    import aer_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF,
    parameter int OWN_W   = OWNER_IN_W
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  scan_ctl_t                  ctl,
    input  logic [$clog2(ENTRIES)-1:0] idx,
    input  logic [AGE_W-1:0]           age,
    input  logic [OWN_W-1:0]           owner,
    input  logic [OWN_W-1:0]           match_owner,
    output logic [$clog2(ENTRIES)-1:0] best_idx,
    output logic                       have_best,
    output logic [AGE_W-1:0]           min_age,
    output logic                       found
);

    localparam int IDX_W = $clog2(ENTRIES);

    logic [AGE_W-1:0] best_age_reg, best_age_next;
    logic [IDX_W-1:0] best_idx_reg, best_idx_next;
    logic             have_reg, have_next;
    logic [AGE_W-1:0] min_age_reg, min_age_next;
    logic             found_reg, found_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_reg  <= 1'b0;
            found_reg <= 1'b0;
        end
        else
        begin
            have_reg  <= have_next;
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_age_reg <= best_age_next;
        best_idx_reg <= best_idx_next;
        min_age_reg  <= min_age_next;
    end

    always_comb
    begin
        best_age_next = best_age_reg;
        best_idx_next = best_idx_reg;
        have_next     = have_reg;
        min_age_next  = min_age_reg;
        found_next    = found_reg;
        if (ctl.clear)
        begin
            best_age_next = '0;
            best_idx_next = '0;
            have_next     = 1'b0;
            min_age_next  = AGE_LIMIT;
            found_next    = 1'b0;
        end
        else if (ctl.data_vld)
        begin
            // strict compare keeps the lowest index on ties
            if (age > best_age_reg)
            begin
                best_age_next = age;
                best_idx_next = idx;
                have_next     = 1'b1;
            end
            if (owner == match_owner)
            begin
                found_next = 1'b1;
                if (age < min_age_reg)
                begin
                    min_age_next = age;
                end
            end
        end
    end

    assign best_idx  = best_idx_reg;
    assign have_best = have_reg;
    assign min_age   = min_age_reg;
    assign found     = found_reg;

endmodule

// ----- hdl/aging_event_record_table.sv -----
// ----------------------------------------------------------------------------
// aging_event_record_table
// table of owner/age records in one ram: record, tick and query requests
// ----------------------------------------------------------------------------
// sequence: record, tick and query scan every stored entry before finish; a
//   record without may_record skips the scan and goes straight to finish
// throughput: one request at a time, one ram read per entry per cycle; the
//   next request is taken the cycle after the result loads, and a result
//   still waiting on the output holds the next one in finish
// reset: entry count cleared, ram contents left as they are
// ----------------------------------------------------------------------------
module aging_event_record_table
    import aer_pkg::*;
#(
    parameter int ENTRIES    = ENTRIES_DEF,
    parameter int OWNER_BITS = OWNER_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // owner_id[15:0], may_record[16], delta_time[32:17], zero fill
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // action[1:0]
    input  logic [ACT_W-1:0]      s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // newest_age[23:0], owner_found[24], record_dropped[25], zero fill
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    localparam int OWN_W  = (OWNER_BITS < OWNER_IN_W) ? OWNER_BITS : OWNER_IN_W;
    localparam int IDX_W  = $clog2(ENTRIES);
    localparam int CNT_W  = $clog2(ENTRIES + 1);
    localparam int WORD_W = OWN_W + AGE_W;

    state_t             state_reg, state_next;
    logic [ACT_W-1:0]   act_reg, act_next;
    logic [OWN_W-1:0]   own_reg, own_next;
    logic               rec_ok_reg, rec_ok_next;
    logic [DELTA_W-1:0] delta_reg, delta_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [CNT_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic               pend_reg, pend_next;
    logic [IDX_W-1:0]   pend_idx_reg, pend_idx_next;
    logic               m_valid_reg, m_valid_next;
    logic [OUT_DATA_W-1:0] m_data_reg, m_data_next;

    logic               in_fire;
    logic               issue;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [WORD_W-1:0]  wr_data;
    logic [WORD_W-1:0]  rd_data;
    logic [AGE_W-1:0]   rd_age;
    logic [OWN_W-1:0]   rd_owner;
    logic [AGE_W:0]     age_sum;
    logic [AGE_W-1:0]   age_sat;
    scan_ctl_t          scan_ctl;
    logic [IDX_W-1:0]   best_idx;
    logic               have_best;
    logic [AGE_W-1:0]   min_age;
    logic               found;
    logic               dropped;

    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign rd_age   = rd_data[AGE_W-1:0];
    assign rd_owner = rd_data[WORD_W-1:AGE_W];
    assign issue    = (state_reg == ST_SCAN) && (rd_ptr_reg < cnt_reg);
    assign age_sum  = {1'b0, rd_age} + (AGE_W + 1)'(delta_reg);
    assign age_sat  = (age_sum > {1'b0, AGE_LIMIT}) ? AGE_LIMIT : age_sum[AGE_W-1:0];

    assign scan_ctl.clear    = in_fire;
    assign scan_ctl.data_vld = pend_reg;

    aer_ram #(
        .DEPTH (ENTRIES),
        .WIDTH (WORD_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (issue),
        .rd_addr (rd_ptr_reg[IDX_W-1:0]),
        .rd_data (rd_data)
    );

    aer_scan #(
        .ENTRIES (ENTRIES),
        .OWN_W   (OWN_W)
    ) u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (scan_ctl),
        .idx         (pend_idx_reg),
        .age         (rd_age),
        .owner       (rd_owner),
        .match_owner (own_reg),
        .best_idx    (best_idx),
        .have_best   (have_best),
        .min_age     (min_age),
        .found       (found)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            rd_ptr_reg  <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            rd_ptr_reg  <= rd_ptr_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg      <= act_next;
        own_reg      <= own_next;
        rec_ok_reg   <= rec_ok_next;
        delta_reg    <= delta_next;
        pend_idx_reg <= pend_idx_next;
        m_data_reg   <= m_data_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        act_next      = act_reg;
        own_next      = own_reg;
        rec_ok_next   = rec_ok_reg;
        delta_next    = delta_reg;
        cnt_next      = cnt_reg;
        rd_ptr_next   = rd_ptr_reg;
        pend_next     = issue;
        pend_idx_next = rd_ptr_reg[IDX_W-1:0];
        m_valid_next  = m_valid_reg && !m_axis_tready;
        m_data_next   = m_data_reg;
        s_axis_tready = 1'b0;
        wr_en         = 1'b0;
        wr_addr       = pend_idx_reg;
        wr_data       = {rd_owner, age_sat};
        dropped       = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    act_next    = s_axis_tuser;
                    own_next    = s_axis_tdata[OWN_W-1:0];
                    rec_ok_next = s_axis_tdata[16];
                    delta_next  = s_axis_tdata[32:17];
                    rd_ptr_next = '0;
                    if (s_axis_tuser == ACT_TICK || s_axis_tuser == ACT_QUERY ||
                        (s_axis_tuser == ACT_RECORD && s_axis_tdata[16]))
                    begin
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end

            ST_SCAN:
            begin
                if (issue)
                begin
                    rd_ptr_next = rd_ptr_reg + 1'b1;
                end
                // tick writes back the entry read in the previous cycle
                if (pend_reg && act_reg == ACT_TICK)
                begin
                    wr_en = 1'b1;
                end
                if (!issue && !pend_reg)
                begin
                    state_next = ST_FINISH;
                end
            end

            ST_FINISH:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    if (act_reg == ACT_RECORD && rec_ok_reg)
                    begin
                        wr_data = {own_reg, {AGE_W{1'b0}}};
                        if (have_best)
                        begin
                            wr_en   = 1'b1;
                            wr_addr = best_idx;
                        end
                        else if (cnt_reg < CNT_W'(ENTRIES))
                        begin
                            wr_en    = 1'b1;
                            wr_addr  = cnt_reg[IDX_W-1:0];
                            cnt_next = cnt_reg + 1'b1;
                        end
                        else
                        begin
                            dropped = 1'b1;
                        end
                    end
                    m_valid_next = 1'b1;
                    if (act_reg == ACT_QUERY)
                    begin
                        m_data_next = {{(OUT_DATA_W - AGE_W - 2){1'b0}}, 1'b0, found, min_age};
                    end
                    else
                    begin
                        m_data_next = {{(OUT_DATA_W - AGE_W - 2){1'b0}}, dropped, 1'b0,
                                       {AGE_W{1'b0}}};
                    end
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(ENTRIES))
        else $error("entry count beyond table size");

    a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg != $past(cnt_reg)) |-> (cnt_reg == $past(cnt_reg) + 1'b1))
        else $error("entry count moved by more than one");

    a_wr_state: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (state_reg == ST_SCAN || state_reg == ST_FINISH))
        else $error("ram write outside scan or finish");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg != ST_IDLE))
        else $error("accepted request did not start");

    a_rd_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (rd_ptr_reg <= cnt_reg))
        else $error("read pointer ran past entry count");

endmodule
